[src/prq_pkg.sv]
// Shared types and codes for the priority ready queue.
// Holds the input and result word layouts and the status and kind codes.
// No dependencies.
package prq_pkg;

  // Field widths of the words on the ports.
  localparam int unsigned KIND_W   = 1;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 7;

  // Operation carried by an input word.
  localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_POP    = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   process_id;
    logic [PRIO_W-1:0] prio_level;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_prio;
    logic [CNT_W-1:0]  entry_count;
  } out_word_t;

endpackage

[src/prq_slot_store.sv]
// Entry store of the priority ready queue: a ring of slots addressed by
// position from the head, one write and one registered read per cycle.
// Depends on nothing beyond its parameters.
module prq_slot_store #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 6,
  parameter int unsigned PRIO_BITS   = 3,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic [AW-1:0]        head_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_pos_i,
  output logic [ID_BITS-1:0]   rd_id_o,
  output logic [PRIO_BITS-1:0] rd_prio_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_pos_i,
  input  logic [ID_BITS-1:0]   wr_id_i,
  input  logic [PRIO_BITS-1:0] wr_prio_i
);

  logic [ID_BITS-1:0]   id_mem   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prio_mem [QUEUE_DEPTH];

  logic [AW:0]   rd_sum, wr_sum;
  logic [AW-1:0] rd_addr, wr_addr;

  // Map a position from the head onto a slot, wrapping once round the ring.
  always_comb begin
    rd_sum = {1'b0, head_i} + {1'b0, rd_pos_i};
    wr_sum = {1'b0, head_i} + {1'b0, wr_pos_i};
    if (rd_sum >= (AW+1)'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - (AW+1)'(QUEUE_DEPTH);
    end
    if (wr_sum >= (AW+1)'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - (AW+1)'(QUEUE_DEPTH);
    end
    rd_addr = rd_sum[AW-1:0];
    wr_addr = wr_sum[AW-1:0];
  end

  // Slot write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_mem[wr_addr]   <= wr_id_i;
      prio_mem[wr_addr] <= wr_prio_i;
    end
    if (rd_en_i) begin
      rd_id_o   <= id_mem[rd_addr];
      rd_prio_o <= prio_mem[rd_addr];
    end
  end

endmodule

[src/priority_ready_queue_unit.sv]
// Priority ready queue: entries sorted by priority number, FIFO within one
// priority. Insert walks back from the tail one entry per cycle, shifting
// each larger-numbered entry one slot on through the single slot store port.
// One item at a time: the next word can be taken in the cycle after the
// result word is loaded, and an output stall holds the finished item back.
// Reset clears the count, head and control registers; slots are not cleared.
module priority_ready_queue_unit
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 6,
  parameter int unsigned PRIO_BITS   = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_POP_WAIT,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic [AW-1:0]        head_q;
  logic [AW-1:0]        pos_q;
  logic [ID_BITS-1:0]   new_id_q;
  logic [PRIO_BITS-1:0] new_prio_q;
  out_word_t            res_q;
  logic                 out_valid_q;
  out_word_t            out_data_q;

  logic                 in_acc;
  logic                 is_full, is_empty;
  logic [ID_BITS-1:0]   in_id;
  logic [PRIO_BITS-1:0] in_prio;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_pos, wr_pos;
  logic [ID_BITS-1:0]   wr_id, rd_id;
  logic [PRIO_BITS-1:0] wr_prio, rd_prio;
  logic                 shift_on;
  logic                 out_free;
  logic [CW-1:0]        count_inc, count_dec;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_full     = (count_q == CW'(QUEUE_DEPTH));
  assign is_empty    = (count_q == '0);
  assign in_id       = ID_BITS'(in_data_i.process_id);
  assign in_prio     = PRIO_BITS'(in_data_i.prio_level);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign count_inc   = count_q + 1'b1;
  assign count_dec   = count_q - 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The entry just read moves back while its number exceeds the new one.
  assign shift_on = (rd_prio > new_prio_q);

  // Slot store port control for the walk and for the pop read.
  always_comb begin
    rd_en   = 1'b0;
    rd_pos  = '0;
    wr_en   = 1'b0;
    wr_pos  = pos_q;
    wr_id   = new_id_q;
    wr_prio = new_prio_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.kind == KIND_INSERT) && !is_full && !is_empty) begin
          rd_en  = 1'b1;
          rd_pos = AW'(count_q - 1'b1);
        end else if (in_acc && (in_data_i.kind == KIND_POP) && !is_empty) begin
          rd_en  = 1'b1;
          rd_pos = '0;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (shift_on) begin
          wr_id   = rd_id;
          wr_prio = rd_prio;
          if (pos_q > AW'(1)) begin
            rd_en  = 1'b1;
            rd_pos = (pos_q - 1'b1) - 1'b1;
          end
        end
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  prq_slot_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .PRIO_BITS  (PRIO_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .head_i   (head_q),
    .rd_en_i  (rd_en),
    .rd_pos_i (rd_pos),
    .rd_id_o  (rd_id),
    .rd_prio_o(rd_prio),
    .wr_en_i  (wr_en),
    .wr_pos_i (wr_pos),
    .wr_id_i  (wr_id),
    .wr_prio_i(wr_prio)
  );

  // Sequencer, queue bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      pos_q       <= '0;
      new_id_q    <= '0;
      new_prio_q  <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            new_id_q          <= in_id;
            new_prio_q        <= in_prio;
            res_q.out_id      <= '0;
            res_q.out_prio    <= '0;
            res_q.entry_count <= CNT_W'(count_q);
            if (in_data_i.kind == KIND_INSERT) begin
              if (is_full) begin
                res_q.status <= STATUS_FULL;
                state_q      <= S_DONE;
              end else if (is_empty) begin
                pos_q   <= '0;
                state_q <= S_INS_PUT;
              end else begin
                pos_q   <= AW'(count_q);
                state_q <= S_INS_CMP;
              end
            end else begin
              if (is_empty) begin
                res_q.status <= STATUS_EMPTY;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_POP_WAIT;
              end
            end
          end
        end
        S_INS_CMP: begin
          if (!shift_on) begin
            count_q           <= count_inc;
            res_q.status      <= STATUS_DONE;
            res_q.entry_count <= CNT_W'(count_inc);
            state_q           <= S_DONE;
          end else if (pos_q == AW'(1)) begin
            pos_q   <= '0;
            state_q <= S_INS_PUT;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        S_INS_PUT: begin
          count_q           <= count_inc;
          res_q.status      <= STATUS_DONE;
          res_q.entry_count <= CNT_W'(count_inc);
          state_q           <= S_DONE;
        end
        S_POP_WAIT: begin
          count_q           <= count_dec;
          head_q            <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          res_q.status      <= STATUS_DONE;
          res_q.out_id      <= ID_W'(rd_id);
          res_q.out_prio    <= PRIO_W'(rd_prio);
          res_q.entry_count <= CNT_W'(count_dec);
          state_q           <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // The walk only runs on a queue that is neither empty nor full.
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP) |-> (!is_empty && !is_full && (pos_q != '0)))
    else $error("insert walk on an empty or full queue");

  // A successful pop removes exactly one entry.
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_WAIT) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not remove one entry");

  // A finished result enters the output register once it is free.
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished result not presented");

endmodule

[tb/priority_ready_queue_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for priority_ready_queue_unit: drives insert and pop words, predicts
// each result word from its own copy of the sorted queue and checks every field.
// Depends on prq_pkg and the priority_ready_queue_unit RTL.
module priority_ready_queue_unit_tb;
  import prq_pkg::*;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned DRAIN_GAP = DEPTH + 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  // Predicted queue contents, head at index 0.
  logic [ID_W-1:0]   q_pid [DEPTH];
  logic [PRIO_W-1:0] q_prio[DEPTH];
  int unsigned       q_fill;

  // Result words still to come, oldest first.
  out_word_t pending_results[$];
  int unsigned fail_count;

  // Idling controls for each side.
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold_reqs;
  int unsigned rx_hold_seen;
  int unsigned rx_hold_left;
  int unsigned rx_burst_left;

  priority_ready_queue_unit #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS    (ID_W),
    .PRIO_BITS  (PRIO_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one accepted word to the predicted queue and return its result word.
  function automatic out_word_t queue_apply(in_word_t w);
    out_word_t   r;
    int unsigned pos;
    r = '0;
    r.status = STATUS_DONE;
    if (w.kind == KIND_INSERT) begin
      if (q_fill >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // Sits behind every entry of equal or lower number.
        pos = 0;
        while (pos < q_fill && q_prio[pos] <= w.prio_level) pos++;
        for (int k = q_fill; k > pos; k--) begin
          q_pid[k]  = q_pid[k-1];
          q_prio[k] = q_prio[k-1];
        end
        q_pid[pos]  = w.process_id;
        q_prio[pos] = w.prio_level;
        q_fill++;
      end
    end else begin
      if (q_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.out_id   = q_pid[0];
        r.out_prio = q_prio[0];
        for (int k = 1; k < q_fill; k++) begin
          q_pid[k-1]  = q_pid[k];
          q_prio[k-1] = q_prio[k];
        end
        q_fill--;
      end
    end
    r.entry_count = CNT_W'(q_fill);
    return r;
  endfunction

  function automatic in_word_t make_word(logic [KIND_W-1:0] kind, int unsigned pid,
                                         int unsigned prio);
    in_word_t w;
    w.kind       = kind;
    w.process_id = ID_W'(pid);
    w.prio_level = PRIO_W'(prio);
    return w;
  endfunction

  // Random word; priorities often bunch on two numbers to exercise FIFO order.
  function automatic in_word_t rand_word(int unsigned insert_pct);
    logic [KIND_W-1:0] kind;
    int unsigned       prio;
    kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
    if ($urandom_range(0, 3) == 0) prio = $urandom_range(2, 3);
    else prio = $urandom_range(0, 7);
    return make_word(kind, $urandom_range(0, 63), prio);
  endfunction

  // Offer one word from a falling edge and return at the falling edge after it
  // is taken. The caller drives the next word or lowers valid at that edge.
  task automatic send_word(in_word_t w);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(queue_apply(w));
    @(negedge clk_i);
  endtask

  // Receiver stall: random bursts, plus a long hold when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = HOLD_LEN;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      out_stall_i <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_burst_left = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result word taken with the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: actual %h", out_data_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.out_id !== want.out_id) begin
          $error("out_id: expected %0d, actual %0d", want.out_id, out_data_o.out_id);
          fail_count++;
        end
        if (out_data_o.out_prio !== want.out_prio) begin
          $error("out_prio: expected %0d, actual %0d", want.out_prio, out_data_o.out_prio);
          fail_count++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 out_data_o.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Empty queue, priority zero, both id extremes and FIFO order within a priority.
  task automatic test_directed();
    send_word(make_word(KIND_POP, 63, 7));
    send_word(make_word(KIND_INSERT, 0, 0));
    send_word(make_word(KIND_INSERT, 63, 7));
    send_word(make_word(KIND_INSERT, 21, 3));
    send_word(make_word(KIND_INSERT, 42, 3));
    send_word(make_word(KIND_INSERT, 7, 3));
    send_word(make_word(KIND_INSERT, 33, 1));
    send_word(make_word(KIND_INSERT, 12, 7));
    send_word(make_word(KIND_INSERT, 44, 0));
    send_word(make_word(KIND_POP, 0, 0));
    send_word(make_word(KIND_INSERT, 5, 3));
    repeat (9) send_word(make_word(KIND_POP, 0, 0));
    send_word(make_word(KIND_POP, 0, 0));
  endtask

  // Fill to capacity, insert past it, then drain past empty.
  task automatic test_full_and_empty();
    repeat (DEPTH + 2) send_word(rand_word(100));
    repeat (DEPTH + 2) send_word(rand_word(0));
  endtask

  // Long receiver hold while insert and pop words keep coming, so the input stalls.
  task automatic test_receiver_hold();
    rx_hold_reqs++;
    repeat (30) send_word(rand_word(70));
  endtask

  // Sender waits until every result word has arrived, then carries on.
  task automatic test_sender_pause();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (20) send_word(rand_word(50));
  endtask

  // Segments of random words whose insert share swings from draining to filling.
  task automatic test_random_mix(int unsigned segments);
    int unsigned pct;
    repeat (segments) begin
      case ($urandom_range(0, 3))
        0: pct = 10;
        1: pct = 50;
        2: pct = 75;
        default: pct = 95;
      endcase
      repeat (50) send_word(rand_word(pct));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_directed();
    test_full_and_empty();
    test_receiver_hold();
    test_random_mix(11);
    test_sender_pause();
    test_random_mix(11);
    // Closing stretch with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(3);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
src/prq_pkg.sv
src/prq_slot_store.sv
src/priority_ready_queue_unit.sv
tb/priority_ready_queue_unit_tb.sv
